>>> rtl/core/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants of the telemetry frame deframer
// frame layout, status codes, register indexes and the frame record
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int unsigned IDX_W         = 5;
	localparam int unsigned LAST_IDX      = 18;
	localparam int unsigned STORE_DEPTH   = 17;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TDATA_W       = 120;

	localparam logic [7:0] LEN_BYTE_VALUE = 8'd16;
	localparam logic [7:0] START_RESET    = 8'hAA;
	localparam logic [7:0] VERSION_RESET  = 8'h01;

	// register indexes of the configuration port
	localparam logic REG_START_BYTE  = 1'b0;
	localparam logic REG_EXP_VERSION = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_VER = 2'd2,
		ST_BAD_SUM = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] temp_inlet;
		logic signed [15:0] temp_outlet;
		logic [15:0]        pressure;
		logic [15:0]        motor_rpm;
		logic               estop_active;
		logic               door_closed;
		logic               alarm_active;
		logic [15:0]        alarm_code;
		logic [31:0]        uptime_ms;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

endpackage

>>> rtl/core/tfd_front.sv
// ----------------------------------------------------------------------------
// tfd_front: byte hunter and frame collector
// hunts for the start byte, stores the frame, keeps the sum and checks it
// ----------------------------------------------------------------------------
module tfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [7:0]        cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        rx_byte,
	input  tfd_pkg::q_flags_t q_flags,
	output logic              push,
	output tfd_pkg::frame_rec_t rec
);
	import tfd_pkg::*;

	logic [7:0]       start_byte_q;
	logic [7:0]       exp_version_q;
	logic [IDX_W-1:0] byte_idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             accept;
	logic             hunting;
	logic             last_byte;
	logic [IDX_W-1:0] store_idx;
	status_t          status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_RESET;
			exp_version_q <= VERSION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_BYTE:  start_byte_q  <= cfg_wdata;
				REG_EXP_VERSION: exp_version_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign hunting   = (byte_idx_q == '0) || (byte_idx_q > IDX_W'(LAST_IDX));
	assign last_byte = (byte_idx_q == IDX_W'(LAST_IDX));
	// only the checksum byte needs room in the queue
	assign s_tready  = !(last_byte && q_flags.full);
	assign accept    = s_tvalid && s_tready;
	assign push      = accept && last_byte;
	// byte k of the frame sits in entry k-1
	assign store_idx = byte_idx_q - IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			sum_q      <= '0;
		end else if (accept) begin
			if (hunting) begin
				if (rx_byte == start_byte_q) begin
					byte_idx_q <= IDX_W'(1);
					sum_q      <= rx_byte;
				end else begin
					byte_idx_q <= '0;
				end
			end else if (last_byte) begin
				byte_idx_q <= '0;
				sum_q      <= '0;
			end else begin
				byte_idx_q <= byte_idx_q + IDX_W'(1);
				sum_q      <= sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !hunting && !last_byte) begin
			store_q[store_idx] <= rx_byte;
		end
	end

	always_comb begin
		priority if (store_q[0] != LEN_BYTE_VALUE) begin
			status = ST_BAD_LEN;
		end else if (store_q[1] != exp_version_q) begin
			status = ST_BAD_VER;
		end else if (sum_q != rx_byte) begin
			status = ST_BAD_SUM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		rec        = '0;
		rec.status = status;
		if (status == ST_OK) begin
			rec.temp_inlet   = {store_q[3], store_q[2]};
			rec.temp_outlet  = {store_q[5], store_q[4]};
			rec.pressure     = {store_q[7], store_q[6]};
			rec.motor_rpm    = {store_q[9], store_q[8]};
			rec.estop_active = store_q[10][0];
			rec.door_closed  = store_q[10][1];
			rec.alarm_active = store_q[10][2];
			rec.alarm_code   = {store_q[12], store_q[11]};
			rec.uptime_ms    = {store_q[16], store_q[15], store_q[14], store_q[13]};
		end
	end

endmodule

>>> rtl/core/tfd_queue.sv
// ----------------------------------------------------------------------------
// tfd_queue: short queue of frame records
// decouples the collector from the output stage
// ----------------------------------------------------------------------------
module tfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tfd_pkg::frame_rec_t din,
	input  logic                pop,
	output tfd_pkg::frame_rec_t dout,
	output tfd_pkg::q_flags_t   flags
);
	import tfd_pkg::*;

	frame_rec_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign flags.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign flags.empty = (count_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign dout        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> rtl/core/tfd_back.sv
// ----------------------------------------------------------------------------
// tfd_back: output register stage
// takes records from the queue and presents them on the output stream
// ----------------------------------------------------------------------------
module tfd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tfd_pkg::frame_rec_t      din,
	input  tfd_pkg::q_flags_t        q_flags,
	output logic                     pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [tfd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]               m_tuser
);
	import tfd_pkg::*;

	logic       out_valid_q;
	frame_rec_t out_q;

	// refill whenever the register is empty or its transfer completes
	assign pop = !q_flags.empty && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= !q_flags.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= din;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.uptime_ms, out_q.alarm_code, out_q.alarm_active,
		out_q.door_closed, out_q.estop_active, out_q.motor_rpm, out_q.pressure,
		out_q.temp_outlet, out_q.temp_inlet};

endmodule

>>> rtl/core/telemetry_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_core: receiver for 19-byte telemetry frames
//
// input stream s_*: one received byte per transfer in s_tdata[7:0]
// output stream m_*: one record per completed frame, status in m_tuser
// configuration: cfg_we writes cfg_wdata to register cfg_idx
//   (0 start byte, 1 expected version); the user writes only while the block
//   is idle, which the block itself does not enforce
// a byte is taken every cycle while s_tready is high; the collector stores
// the frame and keeps the running sum, and on the checksum byte it pushes a
// record into a two-entry queue. the record leaves the queue through an
// output register, which drives m_tvalid. throughput is one byte per cycle
// while s_tready is high, set by the single collector stage.
// when the receiver stalls, records pile up in the queue and output register;
// with both full, s_tready drops only on a checksum byte.
// reset returns both registers to their defaults, empties the queue and
// starts hunting for the start byte.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [7:0]                  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [15:0] temp_inlet, [31:16] temp_outlet, [47:32] pressure,
	// [63:48] motor_rpm, [64] estop_active, [65] door_closed,
	// [66] alarm_active, [82:67] alarm_code, [114:83] uptime_ms, rest zero
	output logic [tfd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser   // [1:0] status
);
	import tfd_pkg::*;

	q_flags_t   q_flags;
	frame_rec_t push_rec;
	frame_rec_t pop_rec;
	logic       push;
	logic       pop;

	tfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.rx_byte   (s_tdata),
		.q_flags   (q_flags),
		.push      (push),
		.rec       (push_rec)
	);

	tfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_rec),
		.pop    (pop),
		.dout   (pop_rec),
		.flags  (q_flags)
	);

	tfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (pop_rec),
		.q_flags  (q_flags),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/core/tfd_checker.sv
// ----------------------------------------------------------------------------
// tfd_checker: port-level checks of the telemetry frame deframer
// watches the output stream for stalls, padding and rejected frames
// ----------------------------------------------------------------------------
module tfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [tfd_pkg::TDATA_W-1:0] m_tdata,
	input logic [1:0]                  m_tuser
);
	import tfd_pkg::*;

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_pad_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:115] == '0)
		else $error("tdata padding not zero");

	a_reject_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("rejected frame carries data");

endmodule

bind telemetry_frame_deframer_core tfd_checker u_tfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> bench/telemetry_frame_checker.sv
// ----------------------------------------------------------------------------
// telemetry_frame_checker: frame decoder and result check for the deframer
// follows register writes and accepted bytes, decodes the frames itself and
// compares every record leaving the block, field by field, in order
// ----------------------------------------------------------------------------
module telemetry_frame_checker import tfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [7:0]         cfg_wdata,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] rx_byte
	input  logic               m_tvalid,
	input  logic               m_tready,
	// [15:0] temp_inlet, [31:16] temp_outlet, [47:32] pressure,
	// [63:48] motor_rpm, [64] estop_active, [65] door_closed,
	// [66] alarm_active, [82:67] alarm_code, [114:83] uptime_ms
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic [1:0]         m_tuser,  // [1:0] status
	output int                 n_fail,
	output int                 n_pending,
	output int                 n_results,
	output int                 n_ok
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] start_val;
	logic [7:0] version_val;
	logic [4:0] frame_pos;
	logic [7:0] sum8;
	logic [7:0] frame_bytes [0:17];
	frame_rec_t frames_due [$];

	int fail_count   = 0;
	int result_count = 0;
	int ok_count     = 0;

	assign n_fail    = fail_count;
	assign n_results = result_count;
	assign n_ok      = ok_count;

	function automatic logic [15:0] pick16(input int pos);
		return {frame_bytes[pos + 1], frame_bytes[pos]};
	endfunction

	// one received byte: hunt, collect, or close the frame on the checksum byte
	task automatic decode_rx_byte(input logic [7:0] b);
		frame_rec_t rec;
		if (frame_pos == 0) begin
			if (b == start_val) begin
				frame_bytes[0] = b;
				sum8 = b;
				frame_pos = 1;
			end
		end else if (frame_pos < LAST_IDX) begin
			frame_bytes[frame_pos] = b;
			sum8 = sum8 + b;
			frame_pos = frame_pos + 1'b1;
		end else begin
			rec = '0;
			if (frame_bytes[1] != LEN_BYTE_VALUE) begin
				rec.status = ST_BAD_LEN;
			end else if (frame_bytes[2] != version_val) begin
				rec.status = ST_BAD_VER;
			end else if (sum8 != b) begin
				rec.status = ST_BAD_SUM;
			end else begin
				rec.status       = ST_OK;
				rec.temp_inlet   = pick16(3);
				rec.temp_outlet  = pick16(5);
				rec.pressure     = pick16(7);
				rec.motor_rpm    = pick16(9);
				rec.estop_active = frame_bytes[11][0];
				rec.door_closed  = frame_bytes[11][1];
				rec.alarm_active = frame_bytes[11][2];
				rec.alarm_code   = pick16(12);
				rec.uptime_ms    = {pick16(16), pick16(14)};
			end
			frames_due.push_back(rec);
			frame_pos = 0;
			sum8 = 0;
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	task automatic check_record(input frame_rec_t got);
		frame_rec_t want;
		if (frames_due.size() == 0) begin
			$display("%0t ns: unexpected record, status %0d, got %0h", $time, got.status,
				got);
			fail_count++;
		end else begin
			want = frames_due.pop_front();
			result_count++;
			if (want.status == ST_OK)
				ok_count++;
			check_field("status", want.status, got.status);
			check_field("temp_inlet", want.temp_inlet, got.temp_inlet);
			check_field("temp_outlet", want.temp_outlet, got.temp_outlet);
			check_field("pressure", want.pressure, got.pressure);
			check_field("motor_rpm", want.motor_rpm, got.motor_rpm);
			check_field("estop_active", want.estop_active, got.estop_active);
			check_field("door_closed", want.door_closed, got.door_closed);
			check_field("alarm_active", want.alarm_active, got.alarm_active);
			check_field("alarm_code", want.alarm_code, got.alarm_code);
			check_field("uptime_ms", want.uptime_ms, got.uptime_ms);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_rec_t got;
		if (!arst_n) begin
			start_val   = START_RESET;
			version_val = VERSION_RESET;
			frame_pos   = 0;
			sum8        = 0;
			frames_due.delete();
		end else begin
			// a record leaves only after passing the queue and the output register,
			// so the output side is handled before the input side
			if (m_tvalid && m_tready) begin
				got.status       = status_t'(m_tuser);
				got.temp_inlet   = m_tdata[15:0];
				got.temp_outlet  = m_tdata[31:16];
				got.pressure     = m_tdata[47:32];
				got.motor_rpm    = m_tdata[63:48];
				got.estop_active = m_tdata[64];
				got.door_closed  = m_tdata[65];
				got.alarm_active = m_tdata[66];
				got.alarm_code   = m_tdata[82:67];
				got.uptime_ms    = m_tdata[114:83];
				check_record(got);
			end
			if (s_tvalid && s_tready)
				decode_rx_byte(s_tdata);
			if (cfg_we) begin
				if (cfg_idx == REG_START_BYTE)
					start_val = cfg_wdata;
				else
					version_val = cfg_wdata;
			end
		end
		n_pending = frames_due.size();
	end

endmodule

>>> bench/tb_telemetry_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_telemetry_frame_deframer_core: testbench of the telemetry frame deframer
// feeds byte streams of good, corrupted and cut frames mixed with line noise
// under several start byte and version settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_telemetry_frame_deframer_core import tfd_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {FR_OK, FR_BAD_LEN, FR_BAD_VER, FR_BAD_SUM, FR_CUT} frame_kind_e;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_idx   = 1'b0;
	logic [7:0]         cfg_wdata = 8'h00;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = 8'h00;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;

	int n_fail;
	int n_pending;
	int n_results;
	int n_ok;

	bit         gaps_on    = 1'b1;
	bit         stalls_on  = 1'b1;
	int         bytes_sent = 0;
	int         settings   = 1;
	logic [7:0] tx_bytes [$];

	telemetry_frame_deframer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	telemetry_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.n_results (n_results),
		.n_ok      (n_ok)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= !stalls_on || ($urandom_range(99) >= 28);
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic push_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_queued();
		while (tx_bytes.size() > 0)
			push_byte(tx_bytes.pop_front());
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		wait (n_pending == 0);
		// a frame record may still be on its way out
		repeat (6) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic make_body(input logic [7:0] sb, ver, output logic [7:0] body [18]);
		int r;
		body[0] = sb;
		body[1] = LEN_BYTE_VALUE;
		body[2] = ver;
		for (int i = 3; i < 18; i++) begin
			r = $urandom_range(15);
			if (r == 0)
				body[i] = sb;
			else if (r == 1)
				body[i] = 8'h00;
			else if (r == 2)
				body[i] = 8'hFF;
			else
				body[i] = $urandom_range(255);
		end
	endtask

	// appends the checksum, applies the requested damage and queues the frame
	task automatic queue_frame(input frame_kind_e kind, input logic [7:0] ver,
		input logic [7:0] body [18]);
		logic [7:0] fb [19];
		logic [7:0] sum;
		int         cut;
		for (int i = 0; i < 18; i++)
			fb[i] = body[i];
		if (kind == FR_BAD_LEN) begin
			do
				fb[1] = $urandom_range(255);
			while (fb[1] == LEN_BYTE_VALUE);
			if ($urandom_range(1))
				fb[2] = $urandom_range(255);
		end
		if (kind == FR_BAD_VER) begin
			do
				fb[2] = $urandom_range(255);
			while (fb[2] == ver);
		end
		sum = 8'h00;
		for (int i = 0; i < 18; i++)
			sum = sum + fb[i];
		fb[18] = sum;
		// length and version faults also carry a bad sum at times, to check priority
		if (kind == FR_BAD_SUM || (kind != FR_OK && kind != FR_CUT && $urandom_range(1)))
			fb[18] = sum ^ (8'h01 << $urandom_range(7));
		cut = (kind == FR_CUT) ? $urandom_range(1, 18) : 19;
		for (int i = 0; i < cut; i++)
			tx_bytes.push_back(fb[i]);
	endtask

	task automatic run_phase(input int n_bytes, input logic [7:0] sb, ver);
		logic [7:0]  body [18];
		frame_kind_e kind;
		int          first;
		int          r;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes) begin
			repeat ($urandom_range(0, 2))
				tx_bytes.push_back($urandom_range(255));
			make_body(sb, ver, body);
			r = $urandom_range(99);
			if (r < 60)
				kind = FR_OK;
			else if (r < 70)
				kind = FR_BAD_LEN;
			else if (r < 80)
				kind = FR_BAD_VER;
			else if (r < 90)
				kind = FR_BAD_SUM;
			else
				kind = FR_CUT;
			queue_frame(kind, ver, body);
			send_queued();
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic new_setting(input logic [7:0] sb, ver);
		write_reg(REG_START_BYTE, sb);
		write_reg(REG_EXP_VERSION, ver);
		settings++;
	endtask

	initial begin
		logic [7:0] body [18];
		logic [7:0] sb;
		logic [7:0] ver;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// defaults: noise while hunting, then a frame of extreme values with
		// the start byte repeated inside its data
		tx_bytes = '{8'h00, 8'hFF, 8'h55};
		body = '{START_RESET, LEN_BYTE_VALUE, VERSION_RESET, 8'h00, 8'h80, 8'hFF, 8'h7F,
			8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, START_RESET, START_RESET,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		queue_frame(FR_OK, VERSION_RESET, body);
		send_queued();
		s_tvalid <= 1'b0;
		run_phase(140, START_RESET, VERSION_RESET);

		new_setting(8'h00, 8'hFF);
		run_phase(140, 8'h00, 8'hFF);

		new_setting(8'hFF, 8'h00);
		run_phase(140, 8'hFF, 8'h00);

		// back-to-back stretch, no gaps and no stalls
		sb  = $urandom_range(255);
		ver = $urandom_range(255);
		new_setting(sb, ver);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		run_phase(160, sb, ver);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;

		repeat (2) begin
			sb  = $urandom_range(255);
			ver = $urandom_range(255);
			new_setting(sb, ver);
			run_phase(120, sb, ver);
		end

		wait (n_pending == 0);
		repeat (10) @(posedge clk);
		$display("sent %0d bytes under %0d register settings", bytes_sent, settings);
		$display("compared %0d frame records, %0d accepted and %0d rejected",
			n_results, n_ok, n_results - n_ok);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
